// ----- hdl/sirr_pkg.sv -----
// Shared types and constants for the downward row recurrence block.
// No dependencies; every other file in hdl/ but sirr_ram imports this package.
package sirr_pkg;

   localparam int VALUE_W  = 16;   // Q8.8 activation / Q4.12 weight
   localparam int HID_W    = 15;   // rectified hidden value, unsigned Q7.8
   localparam int CHAN_W   = 4;
   localparam int POS_FW   = 10;
   localparam int FRAC_SH  = 12;   // weight fraction bits
   localparam int PROD_W   = 32;

   localparam logic REQ_DATA   = 1'b0;
   localparam logic REQ_WEIGHT = 1'b1;

   typedef struct packed {
      logic                       req_type;
      logic [CHAN_W-1:0]          channel;
      logic [CHAN_W-1:0]          source_channel;
      logic [POS_FW-1:0]          position;
      logic                       first_row;
      logic                       row_parity;
      logic signed [VALUE_W-1:0]  value;
   } req_beat_type;

   typedef struct packed {
      logic [HID_W-1:0]   hidden_value;
      logic [CHAN_W-1:0]  out_channel;
      logic [POS_FW-1:0]  out_position;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ROUND
   } ctrl_state_type;

   typedef struct packed {
      logic accept;   // take the beat on the request channel
      logic issue;    // read one weight / previous-row pair
      logic finish;   // write back and load the response register
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_mac;     // in-range data beat needing the dot product
      logic req_first;   // in-range first-row data beat
      logic last_issue;  // current read is the last channel
      logic pipe_busy;   // reads or products still in flight
      logic out_free;    // response register can take a result
   } ctrl_status_type;

endpackage

// ----- hdl/spatial_irnn_row_recurrence.sv -----
// Top level of the downward row recurrence: hidden = ReLU(x + W * previous row).
// Depends on sirr_pkg, sirr_ctrl, sirr_dpath (which holds two sirr_ram instances).
//
// Request channel (req_valid/req_ready/req_data) carries two kinds of beat:
//   weight write - stores W[channel][source_channel], no response.
//   data element - yields one response beat with the rectified unsigned Q7.8 hidden value,
//                  its channel and position; out-of-range elements are dropped.
// Response channel (rsp_valid/rsp_ready/rsp_data) is fed from an output register.
// Path of each data element from accept to response valid:
//   first row: the sequencer goes straight to the round step, which loads the response register.
//   other rows: a sweep reads one weight and one previous-row value per cycle from
//   the two RAMs, the single multiply-accumulate unit adds one product per cycle,
//   and after the drain the round step loads the response register.
// One item is in work at a time; req_ready is high only while the sequencer idles.
// A finished result waits in the output register; the next item is accepted and
// computed meanwhile, and only its write-back waits for the register to free up.
// Reset clears the sequencer, the pipeline valid flags and the response valid flag;
// weight and row buffer contents are undefined until written, and nothing sweeps them.
module spatial_irnn_row_recurrence #(
   parameter int CHANNELS  = 16,
   parameter int POSITIONS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sirr_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sirr_pkg::rsp_beat_type rsp_data
);
   import sirr_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   sirr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sirr_dpath #(
      .CHANNELS  (CHANNELS),
      .POSITIONS (POSITIONS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/sirr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module sirr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/sirr_ctrl.sv -----
// Sequencer for the row recurrence: accept, multiply-accumulate sweep, drain, round.
// Depends on sirr_pkg for the state, command and status types.
module sirr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sirr_pkg::ctrl_status_type status,
   output sirr_pkg::ctrl_cmd_type    cmd
);
   import sirr_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.req_mac) begin
                  state_in = ST_ISSUE;
               end else if (status.req_first) begin
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ISSUE: begin
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_ISSUE: cmd.issue  = 1'b1;
         ST_DRAIN: cmd        = '0;
         ST_ROUND: cmd.finish = status.out_free;
         default:  cmd        = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE && status.last_issue) |=> (state_ff == ST_DRAIN))
      else $error("sweep did not end after the last channel");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !status.pipe_busy)
      else $error("idle with reads or products still in flight");

endmodule

// ----- hdl/sirr_dpath.sv -----
// Datapath: weight RAM, ping-pong row buffer RAM, MAC pipeline, round/ReLU, response reg.
// Depends on sirr_pkg and sirr_ram.
module sirr_dpath #(
   parameter int CHANNELS  = 16,
   parameter int POSITIONS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sirr_pkg::req_beat_type    req_data,
   input  sirr_pkg::ctrl_cmd_type    cmd,
   output sirr_pkg::ctrl_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sirr_pkg::rsp_beat_type    rsp_data
);
   import sirr_pkg::*;

   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W   = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
   localparam int WADDR_W = 2 * CH_W;
   localparam int RADDR_W = 1 + CH_W + POS_W;
   localparam int ACC_W   = PROD_W + CH_W + 2;

   logic              ch_ok, src_ok, pos_ok, is_data;
   logic [CH_W-1:0]   ch_ff, ch_in, k_ff, k_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              parity_ff, parity_in;
   logic              rd_vld_ff, rd_vld_in, mul_vld_ff, mul_vld_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_beat_type             rsp_data_ff, rsp_data_in;

   logic                      w_wr_en;
   logic [WADDR_W-1:0]        w_wr_addr, w_rd_addr;
   logic signed [VALUE_W-1:0] w_rd;
   logic [RADDR_W-1:0]        h_wr_addr, h_rd_addr;
   logic [HID_W-1:0]          h_rd, hidden;
   logic signed [VALUE_W-1:0] hp_ext;

   // request decode
   assign ch_ok   = 32'(req_data.channel) < CHANNELS;
   assign src_ok  = 32'(req_data.source_channel) < CHANNELS;
   assign pos_ok  = 32'(req_data.position) < POSITIONS;
   assign is_data = (req_data.req_type == REQ_DATA);

   assign status.req_mac    = is_data && ch_ok && pos_ok && !req_data.first_row;
   assign status.req_first  = is_data && ch_ok && pos_ok && req_data.first_row;
   assign status.last_issue = (k_ff == CH_W'(CHANNELS - 1));
   assign status.pipe_busy  = rd_vld_ff || mul_vld_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // weight store, W[row][col] at {row, col}
   assign w_wr_en   = cmd.accept && (req_data.req_type == REQ_WEIGHT) && ch_ok && src_ok;
   assign w_wr_addr = {CH_W'(req_data.channel), CH_W'(req_data.source_channel)};
   assign w_rd_addr = {ch_ff, k_ff};

   sirr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (1 << WADDR_W)
   ) u_weights (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (req_data.value),
      .rd_en   (cmd.issue),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd)
   );

   // row buffers at {parity, channel, position}; read the other parity
   assign h_wr_addr = {parity_ff, ch_ff, pos_ff};
   assign h_rd_addr = {~parity_ff, k_ff, pos_ff};

   sirr_ram #(
      .WIDTH (HID_W),
      .DEPTH (1 << RADDR_W)
   ) u_rows (
      .clock   (clock),
      .wr_en   (cmd.finish),
      .wr_addr (h_wr_addr),
      .wr_data (hidden),
      .rd_en   (cmd.issue),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd)
   );

   assign hp_ext = signed'({1'b0, h_rd});

   // acc carries the rounding constant, so the result is a plain floor shift
   always_comb begin
      if (acc_ff[ACC_W-1]) begin
         hidden = '0;
      end else if (|acc_ff[ACC_W-2:FRAC_SH+HID_W]) begin
         hidden = '1;
      end else begin
         hidden = acc_ff[FRAC_SH+HID_W-1:FRAC_SH];
      end
   end

   always_comb begin
      ch_in        = ch_ff;
      pos_in       = pos_ff;
      parity_in    = parity_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rd_vld_in    = cmd.issue;
      mul_vld_in   = rd_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.accept) begin
         ch_in     = CH_W'(req_data.channel);
         pos_in    = POS_W'(req_data.position);
         parity_in = req_data.row_parity;
         k_in      = '0;
         acc_in    = {{(ACC_W-VALUE_W-FRAC_SH){req_data.value[VALUE_W-1]}},
                      req_data.value, 1'b1, {(FRAC_SH-1){1'b0}}};
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end

      if (cmd.issue) begin
         k_in = k_ff + CH_W'(1);
      end

      if (rd_vld_ff) begin
         prod_in = w_rd * hp_ext;
      end

      if (cmd.finish) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.hidden_value = hidden;
         rsp_data_in.out_channel  = CHAN_W'(ch_ff);
         rsp_data_in.out_position = POS_FW'(pos_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= mul_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      pos_ff      <= pos_in;
      parity_ff   <= parity_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken response");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("response appeared without a finished element");

endmodule

// ----- dv/sirr_hidden_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the downward row recurrence: mirrors weights and both row buffers,
// predicts the hidden value of each accepted data beat and checks responses in order.
// Depends on sirr_pkg only.
module sirr_hidden_checker #(
   parameter int CHANNELS  = 16,
   parameter int POSITIONS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  sirr_pkg::req_beat_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sirr_pkg::rsp_beat_type rsp_data,
   output int                     error_count,
   output int                     pending_count
);
   import sirr_pkg::*;

   localparam int HID_MAX = (1 << HID_W) - 1;

   logic signed [VALUE_W-1:0] weight_mem [CHANNELS][CHANNELS];
   logic [VALUE_W-1:0]        hidden_rows [2][CHANNELS][POSITIONS];
   rsp_beat_type              hidden_expected_q [$];
   int                        mismatches = 0;

   // Q8.8 x widened to Q.20, plus Q4.12 * Q8.8 products, round half up, ReLU, saturate
   function automatic logic [HID_W-1:0] predict_hidden(req_beat_type b);
      longint acc;
      longint h;
      acc = longint'($signed(b.value)) * (longint'(1) << FRAC_SH);
      if (!b.first_row) begin
         for (int k = 0; k < CHANNELS; k++)
            acc += longint'(weight_mem[b.channel][k]) *
                   longint'(hidden_rows[!b.row_parity][k][b.position]);
      end
      acc += longint'(1) << (FRAC_SH - 1);
      if (acc <= 0) begin
         h = 0;
      end else begin
         h = acc >>> FRAC_SH;
         if (h > HID_MAX) h = HID_MAX;
      end
      return h[HID_W-1:0];
   endfunction

   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      logic [HID_W-1:0] h;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (hidden_expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t unexpected response beat: h=%0d ch=%0d pos=%0d", $time,
                           got.hidden_value, got.out_channel, got.out_position);
            end else begin
               want = hidden_expected_q.pop_front();
               if (got.hidden_value !== want.hidden_value ||
                   got.out_channel !== want.out_channel ||
                   got.out_position !== want.out_position) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t response mismatch: expected h=%0d ch=%0d pos=%0d, got h=%0d ch=%0d pos=%0d",
                              $time, want.hidden_value, want.out_channel, want.out_position,
                              got.hidden_value, got.out_channel, got.out_position);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.req_type == REQ_WEIGHT) begin
               if (int'(req_data.channel) < CHANNELS && int'(req_data.source_channel) < CHANNELS)
                  weight_mem[req_data.channel][req_data.source_channel] = req_data.value;
            end else if (int'(req_data.channel) < CHANNELS &&
                         int'(req_data.position) < POSITIONS) begin
               h = predict_hidden(req_data);
               hidden_rows[req_data.row_parity][req_data.channel][req_data.position] = {1'b0, h};
               want.hidden_value = h;
               want.out_channel  = req_data.channel;
               want.out_position = req_data.position;
               hidden_expected_q.push_back(want);
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= hidden_expected_q.size();
   end

endmodule

// ----- dv/spatial_irnn_row_recurrence_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for spatial_irnn_row_recurrence: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on sirr_pkg and sirr_hidden_checker.
module spatial_irnn_row_recurrence_tb;
   import sirr_pkg::*;

   localparam int CHANNELS     = 16;
   localparam int POSITIONS    = 1024;
   localparam int RANDOM_ITEMS = 1040;
   localparam int HOLD_AT_BEAT = 450;
   localparam int HOLD_CYCLES  = 250;
   localparam int STUCK_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 60;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_beat_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_beat_type rsp_data;
   int           fail_count;
   int           pending_count;

   // stimulus-side bookkeeping so no unwritten weight or row entry is ever read
   bit [CHANNELS-1:0]  rows_written [2][POSITIONS];
   bit [CHANNELS-1:0]  weight_rows_set [CHANNELS];
   logic [POS_FW-1:0]  hot_positions [8];
   int                 beats_sent = 0;
   bit                 quiet = 1'b0;
   int                 stuck_cycles = 0;

   spatial_irnn_row_recurrence #(
      .CHANNELS  (CHANNELS),
      .POSITIONS (POSITIONS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sirr_hidden_checker #(
      .CHANNELS  (CHANNELS),
      .POSITIONS (POSITIONS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic req_beat_type data_beat(int ch, int pos, bit first, bit par,
                                              logic [VALUE_W-1:0] val, int src);
      req_beat_type b;
      b.req_type       = REQ_DATA;
      b.channel        = CHAN_W'(ch);
      b.source_channel = CHAN_W'(src);
      b.position       = POS_FW'(pos);
      b.first_row      = first;
      b.row_parity     = par;
      b.value          = val;
      return b;
   endfunction

   function automatic req_beat_type weight_beat(int ch, int src, logic [VALUE_W-1:0] val);
      req_beat_type b;
      b.req_type       = REQ_WEIGHT;
      b.channel        = CHAN_W'(ch);
      b.source_channel = CHAN_W'(src);
      b.position       = POS_FW'($urandom_range(0, POSITIONS - 1));
      b.first_row      = 1'($urandom_range(0, 1));
      b.row_parity     = 1'($urandom_range(0, 1));
      b.value          = val;
      return b;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_activation();
      int roll;
      logic [VALUE_W-1:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         case ($urandom_range(0, 4))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = 16'h0000;
            3: v = 16'h0001;
            default: v = 16'hFFFF;
         endcase
      end else if (roll < 40) begin
         v = VALUE_W'($urandom);
      end else begin
         v = VALUE_W'($urandom_range(0, 16'h1FFF));
         if ($urandom_range(0, 1)) v = -v;
      end
      return v;
   endfunction

   // mostly small weights so the recurrence neither always saturates nor always clips
   function automatic logic [VALUE_W-1:0] pick_weight();
      int roll;
      logic [VALUE_W-1:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end else if (roll < 15) begin
         v = VALUE_W'($urandom);
      end else begin
         v = VALUE_W'($urandom_range(0, 16'h0300));
         if ($urandom_range(0, 1)) v = -v;
      end
      return v;
   endfunction

   task automatic send_beat(input req_beat_type b);
      int gap;
      gap = 0;
      if (!quiet) begin
         while ($urandom_range(0, 99) < 38) gap++;
         if ($urandom_range(0, 99) < 4) gap += $urandom_range(5, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      if (b.req_type == REQ_WEIGHT) begin
         if (int'(b.channel) < CHANNELS && int'(b.source_channel) < CHANNELS)
            weight_rows_set[b.channel][b.source_channel] = 1'b1;
      end else if (int'(b.channel) < CHANNELS && int'(b.position) < POSITIONS) begin
         rows_written[b.row_parity][b.position][b.channel] = 1'b1;
      end
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // Row-structured traffic: a recurrent element once the row above is complete at
   // that position, otherwise a first-row element filling that row; plus noise.
   task automatic pick_next_beat(output req_beat_type b);
      int roll;
      int ch;
      int pos;
      bit par;
      roll = $urandom_range(0, 99);
      ch   = $urandom_range(0, CHANNELS - 1);
      par  = 1'($urandom_range(0, 1));
      if (roll < 12) begin
         b = weight_beat(ch, $urandom_range(0, CHANNELS - 1), pick_weight());
      end else if (roll < 30) begin
         b = data_beat(ch, $urandom_range(0, POSITIONS - 1), 1'b1, par, pick_activation(),
                       $urandom_range(0, CHANNELS - 1));
      end else begin
         pos = int'(hot_positions[3'($urandom_range(0, 7))]);
         if (rows_written[!par][pos] == '1 && weight_rows_set[ch] == '1) begin
            b = data_beat(ch, pos, 1'b0, par, pick_activation(),
                          $urandom_range(0, CHANNELS - 1));
         end else begin
            for (int k = CHANNELS - 1; k >= 0; k--)
               if (!rows_written[!par][pos][k]) ch = k;
            b = data_beat(ch, pos, 1'b1, !par, pick_activation(),
                          $urandom_range(0, CHANNELS - 1));
         end
      end
   endtask

   initial begin
      req_beat_type b;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      hot_positions = '{10'd0, 10'd1023, 10'd1, 10'd512, 10'd341, 10'd682, 10'd170, 10'd853};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // weight-write extremes, then first-row corner cases
      send_beat(weight_beat(0, 0, 16'h7FFF));
      send_beat(weight_beat(CHANNELS - 1, CHANNELS - 1, 16'h8000));
      send_beat(weight_beat(0, CHANNELS - 1, 16'h0000));
      send_beat(data_beat(0, 0, 1'b1, 1'b0, 16'h7FFF, 0));
      send_beat(data_beat(CHANNELS - 1, POSITIONS - 1, 1'b1, 1'b1, 16'h8000, 15));
      send_beat(data_beat(5, 10'h155, 1'b1, 1'b0, 16'h0000, 10));
      send_beat(data_beat(10, 10'h2AA, 1'b1, 1'b1, 16'h0001, 5));
      send_beat(data_beat(3, 7, 1'b1, 1'b0, 16'hFFFF, 0));
      send_beat(data_beat(12, 600, 1'b1, 1'b1, 16'h0100, 15));
      send_beat(data_beat(7, 300, 1'b1, 1'b0, 16'h4000, 3));

      // full weight matrix, so every channel may recur
      for (int c = 0; c < CHANNELS; c++)
         for (int s = 0; s < CHANNELS; s++)
            send_beat(weight_beat(c, s, pick_weight()));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 700 && n < 900);
         if (n == 1000) begin
            // sender pause: let every outstanding response drain first
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         pick_next_beat(b);
         send_beat(b);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS spatial_irnn_row_recurrence");
      else
         $display("FAIL spatial_irnn_row_recurrence");
      $finish;
   end

   // response side: random back-pressure, one long hold-off so the block backs up
   initial begin
      bit held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && beats_sent >= HOLD_AT_BEAT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 38);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAIL spatial_irnn_row_recurrence");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

endmodule
